// File: sv/hlc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hlc_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueIdxW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_SLASH      = 8'h2F;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_DASH       = 8'h2D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CASE_BIT      = 8'h20;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_NO_SEG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_end;
    logic [1:0] status;
  } out_item_t;

  // one classified input item: up to a joiner, a character and a status
  typedef struct packed {
    logic       pre_valid;
    logic [7:0] pre_byte;
    logic       chr_valid;
    logic [7:0] chr_byte;
    logic       end_valid;
    status_t    status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage
`default_nettype wire

// File: sv/hierarchical_label_canonicalizer.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   ports                        transfer when
// input     in_push, in_full, in_item    in_push && !in_full
// result    out_pop, out_empty, out_item out_pop && !out_empty
//
// a byte is taken every cycle while the command queue has room; the result
// register hands out one result a cycle while results are popped, so an item yields
// up to three results at the back end and the four-entry command queue absorbs the bursts
// reset is synchronous on rst_n, with no clearing pass
// the two sides stall independently: in_full tracks the queue, out_empty the
// result register
module hierarchical_label_canonicalizer
  import hlc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_push,
  output logic           in_full,
  input  wire in_item_t  in_item,
  input  wire logic      out_pop,
  output logic           out_empty,
  output out_item_t      out_item
);

  cmd_t        cmd, head;
  logic        cmd_push, q_pop;
  queue_stat_t q_stat;

  hlc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .q_stat   (q_stat),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  hlc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cmd_push),
    .push_cmd (cmd),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  hlc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

  assign in_full = q_stat.full;

`ifndef SYNTHESIS
  a_end_status : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_item.is_end) |-> (out_item.status != 2'd3 && out_item.out_byte == CH_NUL))
    else $error("bad status item");
  a_byte_item : assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_item.is_end) |-> (out_item.status == ST_OK && out_item.out_byte != CH_NUL))
    else $error("bad byte item");
  a_pop_feed : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

// File: sv/hlc_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hlc_front
  import hlc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  input  wire in_item_t    in_item,
  input  wire queue_stat_t q_stat,
  output logic             cmd_push,
  output cmd_t             cmd
);

  logic open_r, pend_r, seen_r, bad_r;
  logic open_nxt, pend_nxt, seen_nxt, bad_nxt;
  logic accept, act;
  logic is_sep, is_gap, is_alnum, is_upper;
  logic [7:0] c;

  assign c      = in_item.in_byte;
  assign accept = in_push && !q_stat.full;
  assign act    = in_item.byte_present && !bad_r;

  assign is_sep   = (c == CH_DOT) || (c == CH_SLASH) || (c == CH_COLON) ||
                    (c == CH_BACKSLASH);
  assign is_gap   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)) ||
                    (c == CH_DASH) || (c == CH_UNDERSCORE);
  assign is_upper = (c >= 8'h41) && (c <= 8'h5A);
  assign is_alnum = ((c >= 8'h30) && (c <= 8'h39)) || is_upper ||
                    ((c >= 8'h61) && (c <= 8'h7A));

  always_comb begin
    open_nxt = open_r;
    pend_nxt = pend_r;
    seen_nxt = seen_r;
    bad_nxt  = bad_r;
    cmd           = '0;
    cmd.pre_byte  = CH_DOT;
    cmd.chr_byte  = is_upper ? (c | CASE_BIT) : c;
    cmd.status    = ST_OK;
    if (act) begin
      if (is_sep) begin
        open_nxt = 1'b0;
        pend_nxt = 1'b0;
      end else if (is_gap) begin
        if (open_r) begin
          pend_nxt = 1'b1;
        end
      end else if (is_alnum) begin
        if (!open_r) begin
          cmd.pre_valid = seen_r;
          cmd.pre_byte  = CH_DOT;
          open_nxt      = 1'b1;
          seen_nxt      = 1'b1;
        end else begin
          cmd.pre_valid = pend_r;
          cmd.pre_byte  = CH_UNDERSCORE;
        end
        pend_nxt      = 1'b0;
        cmd.chr_valid = 1'b1;
      end else begin
        bad_nxt = 1'b1;
      end
    end
    if (in_item.end_of_text) begin
      cmd.end_valid = 1'b1;
      cmd.status    = bad_nxt ? ST_BAD : (seen_nxt ? ST_OK : ST_NO_SEG);
      open_nxt = 1'b0;
      pend_nxt = 1'b0;
      seen_nxt = 1'b0;
      bad_nxt  = 1'b0;
    end
  end

  assign cmd_push = accept && (cmd.pre_valid || cmd.chr_valid || cmd.end_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      pend_r <= 1'b0;
      seen_r <= 1'b0;
      bad_r  <= 1'b0;
    end else if (accept) begin
      open_r <= open_nxt;
      pend_r <= pend_nxt;
      seen_r <= seen_nxt;
      bad_r  <= bad_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/hlc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module hlc_queue
  import hlc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cmd_t  push_cmd,
  input  wire logic  pop,
  output cmd_t       head,
  output queue_stat_t stat
);

  cmd_t                 slot_r [QueueDepth];
  logic [QueueIdxW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QueueCntW-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == QueueCntW'(QueueDepth));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QueueCntW'(do_push) - QueueCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

// File: sv/hlc_back.sv
`timescale 1ns / 1ps
`default_nettype none
module hlc_back
  import hlc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        head,
  input  wire queue_stat_t q_stat,
  output logic             q_pop,
  input  wire logic        out_pop,
  output logic             out_empty,
  output out_item_t        out_item
);

  cmd_t      cur_r, cur_nxt;
  logic      ovalid_r, ovalid_nxt;
  out_item_t oitem_r, oitem_nxt;
  logic      slot_free;
  cmd_t      rem;

  assign slot_free = !ovalid_r || out_pop;

  always_comb begin
    rem        = cur_r;
    ovalid_nxt = ovalid_r && !out_pop;
    oitem_nxt  = oitem_r;
    q_pop      = 1'b0;
    if (slot_free && (cur_r.pre_valid || cur_r.chr_valid || cur_r.end_valid)) begin
      ovalid_nxt = 1'b1;
      if (cur_r.pre_valid) begin
        oitem_nxt     = '{out_byte: cur_r.pre_byte, is_end: 1'b0, status: ST_OK};
        rem.pre_valid = 1'b0;
      end else if (cur_r.chr_valid) begin
        oitem_nxt     = '{out_byte: cur_r.chr_byte, is_end: 1'b0, status: ST_OK};
        rem.chr_valid = 1'b0;
      end else begin
        oitem_nxt     = '{out_byte: CH_NUL, is_end: 1'b1, status: cur_r.status};
        rem.end_valid = 1'b0;
      end
    end
    cur_nxt = rem;
    if (!(rem.pre_valid || rem.chr_valid || rem.end_valid) && !q_stat.empty) begin
      cur_nxt = head;
      q_pop   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      cur_r    <= '0;
    end else begin
      ovalid_r <= ovalid_nxt;
      cur_r    <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oitem_r <= oitem_nxt;
  end

  assign out_empty = !ovalid_r;
  assign out_item  = oitem_r;

endmodule
`default_nettype wire

// File: test/hlc_result_checker.sv
`timescale 1ns / 1ps
module hlc_result_checker
  import hlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  input  logic      out_empty,
  input  out_item_t out_item,
  output int        fail_count,
  output int        outstanding,
  output int        results_seen
);

  logic seg_open;
  logic uscore_pending;
  logic seg_seen;
  logic bad_seen;
  out_item_t canon_due[$];

  initial begin
    fail_count   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
    $display("%0t: mismatch on %s, got 'h%0h, expected 'h%0h", $realtime, field, got, want);
    fail_count++;
  endtask

  function automatic void push_char(input logic [7:0] b);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    canon_due = {canon_due, r};
  endfunction

  // expected results of one input item
  function automatic void canonicalize(input in_item_t it);
    logic [7:0] c;
    out_item_t r;
    c = it.in_byte;
    r = '0;
    if (it.byte_present && !bad_seen) begin
      if (c == CH_DOT || c == CH_SLASH || c == CH_COLON || c == CH_BACKSLASH) begin
        seg_open = 1'b0;
        uscore_pending = 1'b0;
      end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR) || c == CH_DASH ||
                   c == CH_UNDERSCORE) begin
        if (seg_open) uscore_pending = 1'b1;
      end else if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                   (c >= "a" && c <= "z")) begin
        if (!seg_open) begin
          if (seg_seen) push_char(CH_DOT);
          seg_open = 1'b1;
          seg_seen = 1'b1;
        end else if (uscore_pending) begin
          push_char(CH_UNDERSCORE);
        end
        uscore_pending = 1'b0;
        push_char((c >= "A" && c <= "Z") ? (c | CASE_BIT) : c);
      end else begin
        bad_seen = 1'b1;
      end
    end
    if (it.end_of_text) begin
      r.is_end = 1'b1;
      r.status = bad_seen ? ST_BAD : (seg_seen ? ST_OK : ST_NO_SEG);
      canon_due = {canon_due, r};
      {seg_open, uscore_pending, seg_seen, bad_seen} = '0;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      {seg_open, uscore_pending, seg_seen, bad_seen} = '0;
      canon_due.delete();
    end else begin
      if (in_push && !in_full) canonicalize(in_item);
      if (out_pop && !out_empty) begin
        results_seen++;
        if (canon_due.size() == 0) begin
          report("unexpected result", out_item.out_byte, 8'h00);
        end else begin
          want = canon_due.pop_front();
          if (out_item.out_byte !== want.out_byte)
            report("out_byte", out_item.out_byte, want.out_byte);
          if (out_item.is_end !== want.is_end)
            report("is_end", 8'(out_item.is_end), 8'(want.is_end));
          if (out_item.status !== want.status)
            report("status", 8'(out_item.status), 8'(want.status));
        end
      end
    end
    outstanding <= canon_due.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import hlc_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 80;
  localparam int RandomItems = 140;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_push = 1'b0;
  in_item_t  in_item = '0;
  logic      in_full;
  logic      out_pop = 1'b0;
  logic      out_empty;
  out_item_t out_item;

  int fail_count;
  int outstanding;
  int results_seen;
  int items_sent = 0;
  int labels_sent = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  hierarchical_label_canonicalizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_item (out_item)
  );

  hlc_result_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .out_pop     (out_pop),
    .out_empty   (out_empty),
    .out_item    (out_item),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(16, 0);
    if (gap > 0) begin
      in_push <= 1'b0;
      in_item <= in_item_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (it.byte_present || it.end_of_text) items_sent++;
  endtask

  task automatic send_text(input string s, input bit end_only);
    in_item_t it;
    for (int i = 0; i < s.len(); i++) begin
      it.in_byte = s[i];
      it.byte_present = 1'b1;
      it.end_of_text = !end_only && (i == s.len() - 1);
      send_item(it);
    end
    if (end_only) begin
      it.in_byte = 8'($urandom_range(255, 0));
      it.byte_present = 1'b0;
      it.end_of_text = 1'b1;
      send_item(it);
    end
    labels_sent++;
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = no_gaps ? 0 : $urandom_range(16, 0);
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
    end
  end

  initial begin
    in_item_t    it;
    logic [7:0]  seps[4];
    logic [7:0]  runs[8];
    int          len;
    int          target;
    bit          end_only;
    seps = '{CH_DOT, CH_SLASH, CH_COLON, CH_BACKSLASH};
    runs = '{CH_SPACE, CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_DASH, CH_UNDERSCORE};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // leading, inner and trailing runs with a closing separator
    send_text(" -Ab\tc_/", 1'b1);
    // joiner, character and status from one transfer
    send_text("x:Y\\z", 1'b0);
    send_text("9#b", 1'b0);
    send_text("-\r.", 1'b1);
    it.in_byte = 8'hFF;
    it.byte_present = 1'b1;
    it.end_of_text = 1'b1;
    send_item(it);
    labels_sent++;
    it.in_byte = 8'h00;
    it.byte_present = 1'b1;
    it.end_of_text = 1'b0;
    send_item(it);
    it.in_byte = 8'hFF;
    it.byte_present = 1'b0;
    it.end_of_text = 1'b1;
    send_item(it);
    labels_sent++;

    target = items_sent + RandomItems;
    while (items_sent < target) begin
      if (labels_sent == 12) hold_req = 1'b1;
      if (labels_sent == 24) begin
        in_push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      no_gaps = hold_req || ($urandom_range(3, 0) == 0);
      len = $urandom_range(8, 1);
      end_only = $urandom_range(1, 0);
      for (int i = 0; i < len; i++) begin
        it.byte_present = 1'b1;
        it.end_of_text = !end_only && (i == len - 1);
        case ($urandom_range(9, 0))
          0, 1, 2: begin
            it.in_byte = 8'h41 + 8'($urandom_range(25, 0));
            if ($urandom_range(1, 0)) it.in_byte = it.in_byte | CASE_BIT;
          end
          3: it.in_byte = 8'h30 + 8'($urandom_range(9, 0));
          4: it.in_byte = seps[$urandom_range(3, 0)];
          5, 6: it.in_byte = runs[$urandom_range(7, 0)];
          7: it.in_byte = 8'($urandom_range(255, 0));
          8: it.in_byte = 8'($urandom_range(255, 128));
          default: begin
            it.in_byte = 8'($urandom_range(255, 0));
            it.byte_present = 1'b0;
          end
        endcase
        send_item(it);
      end
      if (end_only) begin
        it.in_byte = 8'($urandom_range(255, 0));
        it.byte_present = 1'b0;
        it.end_of_text = 1'b1;
        send_item(it);
      end
      labels_sent++;
    end
    in_push <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("ran %0d labels of %0d input items, %0d results compared, %0d mismatches",
             labels_sent, items_sent, results_seen, fail_count);
    $display("included separators, whitespace runs, bad bytes, empty labels, a long output hold-off and a drain pause");
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/hlc_pkg.sv
sv/hlc_front.sv
sv/hlc_queue.sv
sv/hlc_back.sv
sv/hierarchical_label_canonicalizer.sv
test/hlc_result_checker.sv
test/tb_top.sv
